### rtl/core/hcbp_pkg.sv
`default_nettype none

package hcbp_pkg;

   // defaults for the top-level parameters
   localparam int MAX_CODE_LEN_DEF = 32;
   localparam int SYMBOL_COUNT_DEF = 256;

   // fixed field widths
   localparam int FUNC_W      = 2;
   localparam int SYMBOL_W    = 8;
   localparam int CODE_LEN_W  = 6;
   localparam int CODE_BITS_W = 32;
   localparam int BYTE_BITS   = 8;
   localparam int PAD_W       = 3;

   // accumulator holds up to seven leftover bits plus one full code
   localparam int ACC_W   = CODE_BITS_W + BYTE_BITS - 1;
   localparam int PEND_W  = 6;
   localparam int ENTRY_W = CODE_LEN_W + CODE_BITS_W;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_LOAD   = 2'd0,
      FUNC_ENCODE = 2'd1,
      FUNC_FLUSH  = 2'd2
   } func_type;

   typedef struct packed {
      logic [CODE_LEN_W-1:0]  len;
      logic [CODE_BITS_W-1:0] bits;
   } entry_type;

endpackage

`default_nettype wire

### rtl/core/hcbp_ram.sv
`default_nettype none

module hcbp_ram #(
   parameter int WIDTH  = 38,
   parameter int DEPTH  = 256,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/core/huffman_code_bit_packer_unit.sv
`default_nettype none

// channel  direction  handshake               payload
// req      in         req_valid / req_stall   func, symbol, code_length, code_bits
// rsp      out        rsp_valid / rsp_stall   out_byte, byte_valid, pad_bits,
//                                             flush_done, last
//
// load: no beat. flush: always one beat. encode: accept, table read, then one beat per
// completed byte (0 to 4), one per cycle while rsp is not stalled, set by the single code
// shifter and the one-byte output register
// reset clears the sequencer, accumulator and per-entry valid bits at once, so the code
// table reads as empty without any clearing pass; a stalled rsp beat holds the sequencer in
// its emit or flush state, while the next req may be taken as the final beat still waits

module huffman_code_bit_packer_unit #(
   parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF,
   parameter int SYMBOL_COUNT = hcbp_pkg::SYMBOL_COUNT_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [hcbp_pkg::FUNC_W-1:0]       req_func,
   input  wire logic [hcbp_pkg::SYMBOL_W-1:0]     req_symbol,
   input  wire logic [hcbp_pkg::CODE_LEN_W-1:0]   req_code_length,
   input  wire logic [hcbp_pkg::CODE_BITS_W-1:0]  req_code_bits,
   // response channel
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic      [hcbp_pkg::BYTE_BITS-1:0]    rsp_out_byte,
   output logic                                   rsp_byte_valid,
   output logic      [hcbp_pkg::PAD_W-1:0]        rsp_pad_bits,
   output logic                                   rsp_flush_done,
   output logic                                   rsp_last
);

   localparam int ADDR_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
   // stored length saturates to the parameter and to the code field width
   localparam int LEN_CAP = (MAX_CODE_LEN < hcbp_pkg::CODE_BITS_W) ?
                            MAX_CODE_LEN : hcbp_pkg::CODE_BITS_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_EMIT,
      ST_FLUSH
   } state_type;

   // sequencer and accumulator state
   state_type                          state_ff, state_in;
   logic [hcbp_pkg::ACC_W-1:0]         acc_ff, acc_in;      // left aligned bits
   logic [hcbp_pkg::PEND_W-1:0]        pending_ff, pending_in;
   logic [SYMBOL_COUNT-1:0]            valid_ff, valid_in;  // entry written since reset
   logic                               hit_ff, hit_in;

   // output register
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [hcbp_pkg::BYTE_BITS-1:0]     rsp_byte_ff, rsp_byte_in;
   logic                               rsp_bvalid_ff, rsp_bvalid_in;
   logic [hcbp_pkg::PAD_W-1:0]         rsp_pad_ff, rsp_pad_in;
   logic                               rsp_fdone_ff, rsp_fdone_in;
   logic                               rsp_last_ff, rsp_last_in;

   // request decode
   logic                               accept;
   logic                               sym_in_range;
   logic [ADDR_W-1:0]                  req_addr;
   logic [hcbp_pkg::CODE_LEN_W-1:0]    load_len;
   logic [hcbp_pkg::CODE_BITS_W-1:0]   load_mask;
   hcbp_pkg::entry_type                wr_entry;
   logic                               wr_en;
   logic                               rd_en;

   // table lookup and the single code shifter
   logic [hcbp_pkg::ENTRY_W-1:0]       rd_data;
   hcbp_pkg::entry_type                rd_entry;
   logic [hcbp_pkg::CODE_LEN_W-1:0]    look_len;
   logic [hcbp_pkg::CODE_BITS_W-1:0]   look_bits;
   logic [hcbp_pkg::PEND_W-1:0]        pend_sum;
   logic [hcbp_pkg::PEND_W-1:0]        shamt;
   logic [hcbp_pkg::ACC_W-1:0]         shifted;

   // byte emission
   logic                               slot_free;
   logic [hcbp_pkg::PEND_W-1:0]        pend_after;
   logic [hcbp_pkg::PEND_W-1:0]        pad_full;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   // symbols beyond the table are ignored by loads and add nothing on encodes
   assign sym_in_range = {1'b0, req_symbol} < (hcbp_pkg::SYMBOL_W + 1)'(SYMBOL_COUNT);
   assign req_addr     = req_symbol[ADDR_W-1:0];

   // saturate the length, drop code bits above it
   assign load_len  = (req_code_length > hcbp_pkg::CODE_LEN_W'(LEN_CAP)) ?
                      hcbp_pkg::CODE_LEN_W'(LEN_CAP) : req_code_length;
   assign load_mask = (load_len >= hcbp_pkg::CODE_LEN_W'(hcbp_pkg::CODE_BITS_W)) ? '1 :
                      ((hcbp_pkg::CODE_BITS_W'(1) << load_len) - hcbp_pkg::CODE_BITS_W'(1));

   assign wr_entry.len  = load_len;
   assign wr_entry.bits = req_code_bits & load_mask;

   assign wr_en = accept && sym_in_range &&
                  (hcbp_pkg::func_type'(req_func) == hcbp_pkg::FUNC_LOAD);
   assign rd_en = accept && sym_in_range &&
                  (hcbp_pkg::func_type'(req_func) == hcbp_pkg::FUNC_ENCODE);

   hcbp_ram #(
      .WIDTH  (hcbp_pkg::ENTRY_W),
      .DEPTH  (SYMBOL_COUNT),
      .ADDR_W (ADDR_W)
   ) u_code_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (req_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (req_addr),
      .rd_data (rd_data)
   );

   // an entry never written since reset reads as no code
   assign rd_entry  = hcbp_pkg::entry_type'(rd_data);
   assign look_len  = hit_ff ? rd_entry.len  : '0;
   assign look_bits = hit_ff ? rd_entry.bits : '0;

   // new code lands just below the pending bits of the left aligned accumulator
   assign pend_sum = pending_ff + look_len;
   assign shamt    = hcbp_pkg::PEND_W'(hcbp_pkg::ACC_W) - pend_sum;
   assign shifted  = hcbp_pkg::ACC_W'(look_bits) << shamt;

   assign slot_free  = !rsp_valid_ff || !rsp_stall;
   assign pend_after = pending_ff - hcbp_pkg::PEND_W'(hcbp_pkg::BYTE_BITS);
   assign pad_full   = hcbp_pkg::PEND_W'(hcbp_pkg::BYTE_BITS) - pending_ff;

   always_comb begin
      state_in      = state_ff;
      acc_in        = acc_ff;
      pending_in    = pending_ff;
      valid_in      = valid_ff;
      hit_in        = hit_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_byte_in   = rsp_byte_ff;
      rsp_bvalid_in = rsp_bvalid_ff;
      rsp_pad_in    = rsp_pad_ff;
      rsp_fdone_in  = rsp_fdone_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               hit_in = sym_in_range && valid_ff[req_addr];
               unique case (hcbp_pkg::func_type'(req_func))
                  hcbp_pkg::FUNC_LOAD: begin
                     if (sym_in_range) begin
                        valid_in[req_addr] = 1'b1;
                     end
                  end
                  hcbp_pkg::FUNC_ENCODE: begin
                     // out of range: nothing added and fewer than eight bits pending
                     if (sym_in_range) begin
                        state_in = ST_LOOKUP;
                     end
                  end
                  hcbp_pkg::FUNC_FLUSH: begin
                     state_in = ST_FLUSH;
                  end
                  default: begin
                     // unused function code, item dropped
                  end
               endcase
            end
         end

         ST_LOOKUP: begin
            acc_in     = acc_ff | shifted;
            pending_in = pend_sum;
            // no complete byte means no beat for this item
            state_in   = (pend_sum >= hcbp_pkg::PEND_W'(hcbp_pkg::BYTE_BITS)) ?
                         ST_EMIT : ST_IDLE;
         end

         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_byte_in   = acc_ff[hcbp_pkg::ACC_W-1 -: hcbp_pkg::BYTE_BITS];
               rsp_bvalid_in = 1'b1;
               rsp_pad_in    = '0;
               rsp_fdone_in  = 1'b0;
               rsp_last_in   = (pend_after < hcbp_pkg::PEND_W'(hcbp_pkg::BYTE_BITS));
               acc_in        = acc_ff << hcbp_pkg::BYTE_BITS;
               pending_in    = pend_after;
               if (pend_after < hcbp_pkg::PEND_W'(hcbp_pkg::BYTE_BITS)) begin
                  state_in = ST_IDLE;
               end
            end
         end

         ST_FLUSH: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_fdone_in  = 1'b1;
               rsp_last_in   = 1'b1;
               // pending bits sit at the top, zeros below are the pad
               if (pending_ff != '0) begin
                  rsp_byte_in   = acc_ff[hcbp_pkg::ACC_W-1 -: hcbp_pkg::BYTE_BITS];
                  rsp_bvalid_in = 1'b1;
                  rsp_pad_in    = pad_full[hcbp_pkg::PAD_W-1:0];
               end else begin
                  rsp_byte_in   = '0;
                  rsp_bvalid_in = 1'b0;
                  rsp_pad_in    = '0;
               end
               acc_in     = '0;
               pending_in = '0;
               state_in   = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_ff       <= '0;
         pending_ff   <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         pending_ff   <= pending_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      // payload, no reset needed
      hit_ff        <= hit_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_bvalid_ff <= rsp_bvalid_in;
      rsp_pad_ff    <= rsp_pad_in;
      rsp_fdone_ff  <= rsp_fdone_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = rsp_byte_ff;
   assign rsp_byte_valid = rsp_bvalid_ff;
   assign rsp_pad_bits   = rsp_pad_ff;
   assign rsp_flush_done = rsp_fdone_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

`default_nettype wire
